[rtl/abrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrg_pkg: shared types and constants of the bearing unit
// Fixed widths, polynomial constants, compass codes and the octant side band
// that travels with each transaction through the divider.
// ----------------------------------------------------------------------------
package abrg_pkg;

  // Working delta width after normalization or truncation.
  localparam int D16_W = 16;
  // Magnitude width of a working delta after saturation.
  localparam int MAG_W = 15;
  // Normalized magnitudes are kept below 2^NORM_W.
  localparam int NORM_W = 14;
  // Ratio is Q14 and never above 1.0, so it needs 15 bits.
  localparam int RATIO_FRAC = 14;
  localparam int QUOT_W = 15;
  localparam int REM_W = 16;
  localparam int DIV_STEPS = 3;

  localparam int GAIN_W = 12;
  localparam int ANG_W = 14;

  localparam logic [QUOT_W-1:0] POLY_KNEE = 15'h1333;
  localparam logic [GAIN_W-1:0] POLY_GAIN = 12'hB00;
  localparam logic [ANG_W-1:0] POLY_BASE = 14'h2800;
  localparam logic [QUOT_W-1:0] RATIO_ONE = 15'h4000;

  localparam logic [15:0] BRG_NORTH = 16'h0000;
  localparam logic [15:0] BRG_EAST = 16'h4000;
  localparam logic [15:0] BRG_SOUTH = 16'h8000;
  localparam logic [15:0] BRG_WEST = 16'hC000;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_pos;
    logic y_pos;
    logic swapped;
  } abrg_side_t;

endpackage

[rtl/approx_bearing_atan2_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approx_bearing_atan2_unit: 16-bit bearing of a signed delta pair
// Throughput: one transaction per cycle while the output does not stall;
// the five-stage divider and the two registered multiplies of the
// arctangent polynomial are fully pipelined. A stall on the output
// freezes every stage at once; nothing is dropped. Synchronous active-low
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
module approx_bearing_atan2_unit
  import abrg_pkg::*;
#(
  parameter int DELTA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_x,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_bearing
);

  localparam int SH_MAX = DELTA_WIDTH - NORM_W - 1;
  localparam int SH_W = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: saturated magnitudes and their OR -------------
  logic [DELTA_WIDTH-1:0] ux, uy, mag_x, mag_y;
  logic [DELTA_WIDTH-2:0] sat_x, sat_y;

  assign ux    = in_delta_x;
  assign uy    = in_delta_y;
  assign mag_x = ux[DELTA_WIDTH-1] ? (~ux + 1'b1) : ux;
  assign mag_y = uy[DELTA_WIDTH-1] ? (~uy + 1'b1) : uy;
  assign sat_x = mag_x[DELTA_WIDTH-1] ? '1 : mag_x[DELTA_WIDTH-2:0];
  assign sat_y = mag_y[DELTA_WIDTH-1] ? '1 : mag_y[DELTA_WIDTH-2:0];

  logic                          s1_v_r;
  logic                          s1_kind_r;
  logic [DELTA_WIDTH-2:0]        s1_m_r;
  logic signed [DELTA_WIDTH-1:0] s1_x_r, s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_kind;
      s1_m_r    <= sat_x | sat_y;
      s1_x_r    <= in_delta_x;
      s1_y_r    <= in_delta_y;
    end
  end

  // ---------------- stage 2: normalizing shift amount ----------------------
  // Smallest shift that leaves the OR of magnitudes within NORM_W bits.
  logic [SH_W-1:0] sh_nxt;

  always_comb begin
    sh_nxt = '0;
    for (int s = SH_MAX; s >= 0; s--) begin
      if ((s1_m_r >> (s + NORM_W)) == '0) begin
        sh_nxt = SH_W'(s);
      end
    end
  end

  logic                          s2_v_r;
  logic                          s2_kind_r;
  logic [SH_W-1:0]               s2_sh_r;
  logic signed [DELTA_WIDTH-1:0] s2_x_r, s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s2_sh_r   <= sh_nxt;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
    end
  end

  // ---------------- stage 3: arithmetic shift or plain truncation ----------
  logic signed [DELTA_WIDTH-1:0] shx, shy;
  logic signed [D16_W-1:0]       dx_nxt, dy_nxt;

  assign shx    = s2_x_r >>> s2_sh_r;
  assign shy    = s2_y_r >>> s2_sh_r;
  assign dx_nxt = s2_kind_r ? shx[D16_W-1:0] : s2_x_r[D16_W-1:0];
  assign dy_nxt = s2_kind_r ? shy[D16_W-1:0] : s2_y_r[D16_W-1:0];

  logic                    s3_v_r;
  logic                    s3_kind_r;
  logic signed [D16_W-1:0] s3_dx_r, s3_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind_r <= s2_kind_r;
      s3_dx_r   <= dx_nxt;
      s3_dy_r   <= dy_nxt;
    end
  end

  // ---------------- stage 4: octant flags and divider operands -------------
  logic [D16_W-1:0] neg_x, neg_y;
  logic [MAG_W-1:0] ax, ay;
  abrg_side_t       side_nxt;

  assign neg_x = ~s3_dx_r + 1'b1;
  assign neg_y = ~s3_dy_r + 1'b1;
  // The most negative 16-bit value saturates to the largest positive one.
  assign ax = s3_dx_r[D16_W-1] ? (neg_x[D16_W-1] ? '1 : neg_x[MAG_W-1:0])
                               : s3_dx_r[MAG_W-1:0];
  assign ay = s3_dy_r[D16_W-1] ? (neg_y[D16_W-1] ? '1 : neg_y[MAG_W-1:0])
                               : s3_dy_r[MAG_W-1:0];

  always_comb begin
    side_nxt.x_zero  = (s3_dx_r == '0);
    side_nxt.y_zero  = (s3_dy_r == '0);
    side_nxt.x_pos   = !s3_dx_r[D16_W-1] && (s3_dx_r != '0);
    side_nxt.y_pos   = !s3_dy_r[D16_W-1] && (s3_dy_r != '0);
    side_nxt.swapped = (ax > ay);
  end

  logic             s4_v_r;
  logic [MAG_W-1:0] s4_num_r, s4_den_r;
  abrg_side_t       s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num_r  <= side_nxt.swapped ? ay : ax;
      s4_den_r  <= side_nxt.swapped ? ax : ay;
      s4_side_r <= side_nxt;
    end
  end

  // ---------------- divider: five stages ----------------------------------
  logic              div_valid;
  logic [QUOT_W-1:0] div_quot;
  abrg_side_t        div_side;

  abrg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_num    (s4_num_r),
    .in_den    (s4_den_r),
    .in_side   (s4_side_r),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // ---------------- polynomial stage 1: distance from the knee ------------
  logic              p1_v_r;
  logic [QUOT_W-1:0] p1_diff_r, p1_ratio_r;
  abrg_side_t        p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_diff_r  <= (div_quot > POLY_KNEE) ? (div_quot - POLY_KNEE)
                                           : (POLY_KNEE - div_quot);
      p1_ratio_r <= div_quot;
      p1_side_r  <= div_side;
    end
  end

  // ---------------- polynomial stage 2: quadratic correction --------------
  logic [QUOT_W+GAIN_W-1:0] corr_prod;
  logic [ANG_W-1:0]         corr_nxt;

  assign corr_prod = (QUOT_W+GAIN_W)'(p1_diff_r) * (QUOT_W+GAIN_W)'(POLY_GAIN);
  assign corr_nxt  = POLY_BASE - ANG_W'(corr_prod >> RATIO_FRAC);

  logic              p2_v_r;
  logic [ANG_W-1:0]  p2_corr_r;
  logic [QUOT_W-1:0] p2_ratio_r;
  abrg_side_t        p2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_corr_r  <= corr_nxt;
      p2_ratio_r <= p1_ratio_r;
      p2_side_r  <= p1_side_r;
    end
  end

  // ---------------- polynomial stage 3: scale by the ratio ----------------
  logic [ANG_W+QUOT_W-1:0] ang_prod;

  assign ang_prod = (ANG_W+QUOT_W)'(p2_corr_r) * (ANG_W+QUOT_W)'(p2_ratio_r);

  logic             p3_v_r;
  logic [ANG_W-1:0] p3_angle_r;
  abrg_side_t       p3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_angle_r <= ANG_W'(ang_prod >> RATIO_FRAC);
      p3_side_r  <= p2_side_r;
    end
  end

  // ---------------- output stage: octant resolution -----------------------
  logic [15:0] a16;
  logic [15:0] bearing_nxt;

  assign a16 = {{(16 - ANG_W){1'b0}}, p3_angle_r};

  always_comb begin
    if (p3_side_r.x_zero) begin
      bearing_nxt = p3_side_r.y_pos ? BRG_NORTH : BRG_SOUTH;
    end else if (p3_side_r.y_zero) begin
      bearing_nxt = p3_side_r.x_pos ? BRG_EAST : BRG_WEST;
    end else if (p3_side_r.x_pos) begin
      if (p3_side_r.y_pos) begin
        bearing_nxt = p3_side_r.swapped ? (BRG_EAST - a16) : a16;
      end else begin
        bearing_nxt = p3_side_r.swapped ? (a16 + BRG_EAST) : (BRG_SOUTH - a16);
      end
    end else begin
      if (p3_side_r.y_pos) begin
        bearing_nxt = p3_side_r.swapped ? (a16 + BRG_WEST) : (16'd0 - a16);
      end else begin
        bearing_nxt = p3_side_r.swapped ? (BRG_WEST - a16) : (a16 + BRG_SOUTH);
      end
    end
  end

  logic [15:0] out_bearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bearing_r <= bearing_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_bearing = out_bearing_r;

  // ---------------- assertions ---------------------------------------------
  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted transaction did not enter stage 1");

  a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_kind_r |->
      ($signed(s3_dx_r) >= -16'sd16384) && ($signed(s3_dx_r) <= 16'sd16383) &&
      ($signed(s3_dy_r) >= -16'sd16384) && ($signed(s3_dy_r) <= 16'sd16383))
    else $error("normalized delta out of range");

  a_ratio : assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && !div_side.x_zero && !div_side.y_zero |-> div_quot <= RATIO_ONE)
    else $error("ratio above one");

  // With both components zero the divider sees a zero divisor, and the
  // angle is not used by the axis rule.
  a_angle : assert property (@(posedge clk) disable iff (!rst_n)
    p3_v_r && !p3_side_r.x_zero && !p3_side_r.y_zero |-> p3_angle_r <= POLY_BASE)
    else $error("octant angle above its limit");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(p3_v_r) && $stable(p3_angle_r) && $stable(s4_v_r))
    else $error("pipeline moved during a stall");

endmodule

[rtl/abrg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrg_div: pipelined restoring divider for the Q14 ratio
// Computes (num << 14) / den for num <= den, three quotient bits per stage,
// with the octant side band and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module abrg_div
  import abrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_num,
  input  logic [MAG_W-1:0]  in_den,
  input  abrg_side_t        in_side,
  output logic              out_valid,
  output logic [QUOT_W-1:0] out_quot,
  output abrg_side_t        out_side
);

  localparam int NSTG = QUOT_W / DIV_STEPS;

  logic              v_r    [NSTG];
  logic [REM_W-1:0]  rem_r  [NSTG-1];
  logic [MAG_W-1:0]  den_r  [NSTG-1];
  logic [QUOT_W-1:0] quot_r [NSTG];
  abrg_side_t        side_r [NSTG];

  genvar g;
  for (g = 0; g < NSTG; g++) begin : g_stage
    logic              v_src;
    logic [REM_W-1:0]  rem_src;
    logic [MAG_W-1:0]  den_src;
    logic [QUOT_W-1:0] quot_src;
    abrg_side_t        side_src;
    logic [REM_W-1:0]  rem_nxt;
    logic [QUOT_W-1:0] quot_nxt;

    if (g == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = {1'b0, in_num};
      assign den_src  = in_den;
      assign quot_src = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = v_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign den_src  = den_r[g-1];
      assign quot_src = quot_r[g-1];
      assign side_src = side_r[g-1];
    end

    // The partial remainder stays below den after each subtract, so the
    // following left shift never loses a bit.
    always_comb begin : c_steps
      logic [REM_W-1:0]  rem_v;
      logic [QUOT_W-1:0] quot_v;
      logic              ge_v;
      rem_v  = rem_src;
      quot_v = quot_src;
      ge_v   = 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        ge_v = (rem_v >= {1'b0, den_src});
        if (ge_v) begin
          rem_v = rem_v - {1'b0, den_src};
        end
        quot_v = {quot_v[QUOT_W-2:0], ge_v};
        rem_v  = {rem_v[REM_W-2:0], 1'b0};
      end
      rem_nxt  = rem_v;
      quot_nxt = quot_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quot_r[g] <= quot_nxt;
        side_r[g] <= side_src;
      end
    end

    if (g < NSTG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt;
          den_r[g] <= den_src;
        end
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_quot  = quot_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule

[test/bearing_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_checker: prediction and comparison for the bearing unit
// Watches both channels, computes the expected bearing of every accepted
// input transaction and compares it, in order, with each accepted result.
// ----------------------------------------------------------------------------
module bearing_checker
  import abrg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        out_bearing,
  output int                 failures,
  output int                 pending,
  output int                 compared
);

  typedef struct {
    logic               kind;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [15:0]        bearing;
  } bearing_exp_t;

  bearing_exp_t awaited[$];

  // Magnitude of a wide delta as 33 bits, so that the most negative value fits.
  function automatic logic [32:0] wide_mag(logic signed [31:0] v);
    logic [32:0] ext;
    ext = {v[31], v};
    return v[31] ? 33'd0 - ext : ext;
  endfunction

  function automatic logic [15:0] predict_bearing(logic kind, logic signed [31:0] wx,
                                                  logic signed [31:0] wy);
    logic [32:0] sx, sy, m;
    int          sh;
    int          dx, dy;
    logic [31:0] ax, ay, num, den, ratio, diff, angle, r32;
    logic        swap;
    if (!kind) begin
      dx = int'($signed(wx[15:0]));
      dy = int'($signed(wy[15:0]));
    end else begin
      sx = wide_mag(wx);
      sy = wide_mag(wy);
      if (sx > 33'h7FFF_FFFF) sx = 33'h7FFF_FFFF;
      if (sy > 33'h7FFF_FFFF) sy = 33'h7FFF_FFFF;
      m = sx | sy;
      sh = 0;
      while ((m >> sh) > 33'h3FFF) sh++;
      // The shift itself is arithmetic on the true value, so it rounds down.
      dx = int'(wx) >>> sh;
      dy = int'(wy) >>> sh;
    end

    if (dx == 0) return (dy > 0) ? BRG_NORTH : BRG_SOUTH;
    if (dy == 0) return (dx > 0) ? BRG_EAST : BRG_WEST;

    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > 32767) ax = 32767;
    if (ay > 32767) ay = 32767;
    swap = ax > ay;
    num = (swap ? ay : ax) << 14;
    den = swap ? ax : ay;
    ratio = num / den;
    diff = (ratio > 32'(POLY_KNEE)) ? ratio - 32'(POLY_KNEE) : 32'(POLY_KNEE) - ratio;
    angle = ((32'(POLY_BASE) - ((diff * 32'(POLY_GAIN)) >> 14)) * ratio) >> 14;

    if (dx > 0) begin
      if (dy > 0) r32 = swap ? 32'(BRG_EAST) - angle : angle;
      else        r32 = swap ? angle + 32'(BRG_EAST) : 32'(BRG_SOUTH) - angle;
    end else begin
      if (dy > 0) r32 = swap ? angle + 32'(BRG_WEST) : 32'd0 - angle;
      else        r32 = swap ? 32'(BRG_WEST) - angle : angle + 32'(BRG_SOUTH);
    end
    return r32[15:0];
  endfunction

  initial begin
    failures = 0;
    pending = 0;
    compared = 0;
  end

  always @(posedge clk) begin : watch
    bearing_exp_t head;
    bearing_exp_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result transaction: bearing %h", out_bearing);
          failures = failures + 1;
        end else begin
          head = awaited.pop_front();
          compared = compared + 1;
          if (out_bearing !== head.bearing) begin
            $error("bearing mismatch (kind %0d, dx %0d, dy %0d): expected %h, actual %h",
                   head.kind, head.dx, head.dy, head.bearing, out_bearing);
            failures = failures + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.kind = in_kind;
        fresh.dx = in_delta_x;
        fresh.dy = in_delta_y;
        fresh.bearing = predict_bearing(in_kind, in_delta_x, in_delta_y);
        awaited.push_back(fresh);
      end
      pending = awaited.size();
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bearing unit
// Sends directed corner pairs and then random pairs in both modes, with random
// gaps on the input and random stalls on the output, and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
  import abrg_pkg::*;

  localparam int RANDOM_PAIRS = 1530;
  localparam int STALL_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = 1'b0;
  logic signed [31:0] in_delta_x = '0;
  logic signed [31:0] in_delta_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_bearing;

  int  failures, pending, compared;
  int  quiet_cycles = 0;
  int  sent_direct = 0;
  int  sent_wide = 0;
  bit  gaps_on = 1'b1;

  always #5 clk = ~clk;

  approx_bearing_atan2_unit #(.DELTA_WIDTH(32)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_delta_x (in_delta_x),
    .in_delta_y (in_delta_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bearing(out_bearing)
  );

  bearing_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_delta_x (in_delta_x),
    .in_delta_y (in_delta_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bearing(out_bearing),
    .failures   (failures),
    .pending    (pending),
    .compared   (compared)
  );

  always @(negedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next transaction can follow without a bubble.
  task automatic send_pair(logic kind, logic signed [31:0] dx, logic signed [31:0] dy);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_delta_x <= dx;
    in_delta_y <= dy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind) sent_wide++;
    else sent_direct++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_delta();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 20) - 10;
      1: v[31:16] = {16{v[15]}};
      2: v = v >>> $urandom_range(0, 31);
      3: v = '0;
      4: begin
        case ($urandom_range(0, 7))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = -32768;
          3: v = 32767;
          4: v = 16383;
          5: v = -16384;
          6: v = 1;
          default: v = -1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Axis rules, including both components zero.
    send_pair(1'b0, 0, 0);
    send_pair(1'b0, 0, 5);
    send_pair(1'b0, 0, -5);
    send_pair(1'b0, 5, 0);
    send_pair(1'b0, -5, 0);
    // Most negative 16-bit component saturates in the ratio.
    send_pair(1'b0, -32768, -32768);
    send_pair(1'b0, 32767, -32768);
    send_pair(1'b0, -32768, 1);
    // Direct mode ignores the upper half of each delta.
    send_pair(1'b0, 32'shFFFF_0001, 32'sh1234_8000);
    send_pair(1'b0, 100, 100);
    send_pair(1'b0, -300, 7);
    send_pair(1'b0, 7, -300);
    // Normalize mode: most negative wide deltas and saturation of the OR.
    send_pair(1'b1, 32'sh8000_0000, 32'sh8000_0000);
    send_pair(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_pair(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    // Small components lost by the shift: zero takes the axis rule, negative goes to -1.
    send_pair(1'b1, 32'sh7FFF_FFFF, 1);
    send_pair(1'b1, 32'sh7FFF_FFFF, -1);
    send_pair(1'b1, -1, 32'sh4000_0000);
    // Just at and just past the no-shift limit.
    send_pair(1'b1, 16'h3FFF, 16'h3FFF);
    send_pair(1'b1, 32'sh4000, 1);
    send_pair(1'b1, -32'sh4000, -1);
    send_pair(1'b1, 1, -3);
    send_pair(1'b1, 0, 0);
    send_pair(1'b1, 0, 32'sh8000_0000);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      gaps_on = !(i >= 600 && i < 900);
      send_pair(1'($urandom_range(0, 1)), random_delta(), random_delta());
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d direct and %0d normalized transactions; %0d results compared.",
             sent_direct, sent_wide, compared);
    $display("Random gaps and stalls on both channels, with one stretch at full rate.");
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
